/* hw/rtl/ttd_pkg.sv */
// Shared types, register codes and colour helpers for the tile text display
// pixel generator. No dependencies.
package ttd_pkg;

    // Input transaction: snooped bus write or pixel query
    typedef struct packed {
        logic       command;
        logic [15:0] address;
        logic [15:0] data;
        logic [7:0]  pixel_x;
        logic [6:0]  pixel_y;
    } ttd_in_t;

    // Result transaction
    typedef struct packed {
        logic [23:0] rgb;
        logic        is_border;
    } ttd_out_t;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_MAP_BASE     = 2'd0;
    localparam logic [1:0] REG_FONT_BASE    = 2'd1;
    localparam logic [1:0] REG_PALETTE_BASE = 2'd2;
    localparam logic [1:0] REG_BORDER_INDEX = 2'd3;

    localparam logic [7:0] LEVEL_HI  = 8'd170;
    localparam logic [7:0] LEVEL_LO  = 8'd85;
    localparam int         PALETTE_DEPTH = 16;

    // Built-in 16-colour palette
    function automatic logic [23:0] default_colour(input logic [3:0] idx);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        b = idx[0] ? LEVEL_HI : 8'd0;
        g = idx[1] ? LEVEL_HI : 8'd0;
        r = idx[2] ? LEVEL_HI : 8'd0;
        if (idx == 4'd6) begin
            g = LEVEL_LO;            // brown instead of dark yellow
        end else if (idx[3]) begin
            r = r + LEVEL_LO;
            g = g + LEVEL_LO;
            b = b + LEVEL_LO;
        end
        return {r, g, b};
    endfunction

    // 4-bit channels times 17 is nibble replication
    function automatic logic [23:0] expand_colour(input logic [11:0] v);
        return {v[11:8], v[11:8], v[7:4], v[7:4], v[3:0], v[3:0]};
    endfunction

endpackage

/* hw/rtl/tile_text_display_pixel_generator.sv */
// Top level of the tile text display pixel generator: snoop stores, pixel
// pipeline and APB register file. Depends on ttd_pkg.
//
// Usage
//   s_* channel (valid/ready): one transaction is either a snooped 16-bit
//   memory write (command = write) or a pixel query (command = query).
//   Writes landing in the map, font or palette windows update the shadow
//   stores and produce no result. Each query produces exactly one m_*
//   transaction with 24-bit RGB and a border flag.
//   APB port: map_base @0x0, font_base @0x4, palette_base @0x8,
//   border_index @0xC. Write only while the block is idle.
// Sequence
//   Write: taken in idle, which it does not leave. Border query: idle ->
//   colour. Text query: idle -> font -> colour. Colour waits for a free
//   output register. One transaction is in flight at a time. The text path
//   is the chain map RAM read -> font RAM read -> palette lookup; map and
//   font are one synchronous RAM port each, the palette is in flops.
// Reset
//   aresetn (sync, active low) clears the registers and palette, then a
//   clearing pass zeroes the map and font RAMs over max(COLUMNS*ROWS,
//   2*GLYPH_COUNT) addresses (384 at defaults), with s_ready low. APB writes
//   are taken during the pass.
// Backpressure
//   A finished result waits in the output register; the next transaction is
//   still accepted and proceeds until it needs that register.
module tile_text_display_pixel_generator #(
    parameter int COLUMNS     = 32,
    parameter int ROWS        = 12,
    parameter int MARGIN      = 16,
    parameter int GLYPH_COUNT = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  ttd_pkg::ttd_in_t  s_item,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output ttd_pkg::ttd_out_t m_item,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ttd_pkg::*;

    localparam int MAP_DEPTH   = COLUMNS * ROWS;
    localparam int FONT_DEPTH  = 2 * GLYPH_COUNT;
    localparam int MAP_AW      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int FONT_AW     = $clog2(FONT_DEPTH);
    localparam int CLEAR_DEPTH = (MAP_DEPTH > FONT_DEPTH) ? MAP_DEPTH : FONT_DEPTH;
    localparam int CLR_CW      = $clog2(CLEAR_DEPTH + 1);
    localparam int TEXT_W      = COLUMNS * 4;   // cells are 4 px wide
    localparam int TEXT_H      = ROWS * 8;      // and 8 px tall

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FONT,
        ST_COLOR
    } state_t;

    state_t            state_reg;
    logic [CLR_CW-1:0] clr_cnt_reg;

    // configuration registers
    logic [15:0] map_base_reg;
    logic [15:0] font_base_reg;
    logic [15:0] palette_base_reg;
    logic [3:0]  border_index_reg;

    // stores
    logic [15:0] map_mem  [MAP_DEPTH];
    logic [15:0] font_mem [FONT_DEPTH];
    logic [11:0] pal_reg  [PALETTE_DEPTH];

    // pipeline registers
    logic [15:0] map_rdata_reg;
    logic [15:0] font_rdata_reg;
    logic [1:0]  cx_reg;
    logic [2:0]  cy_reg;
    logic        border_reg;
    logic        glyph_ok_reg;
    logic        m_valid_reg;
    ttd_out_t    m_item_reg;

    // -------------------------------------------------------------------
    // APB: pready is tied high, so no wait states
    // -------------------------------------------------------------------
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_base_reg     <= '0;
            font_base_reg    <= '0;
            palette_base_reg <= '0;
            border_index_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_MAP_BASE:     map_base_reg     <= pwdata[15:0];
                REG_FONT_BASE:    font_base_reg    <= pwdata[15:0];
                REG_PALETTE_BASE: palette_base_reg <= pwdata[15:0];
                REG_BORDER_INDEX: border_index_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_MAP_BASE:     prdata = {16'd0, map_base_reg};
            REG_FONT_BASE:    prdata = {16'd0, font_base_reg};
            REG_PALETTE_BASE: prdata = {16'd0, palette_base_reg};
            REG_BORDER_INDEX: prdata = {28'd0, border_index_reg};
            default:          prdata = '0;
        endcase
    end

    // -------------------------------------------------------------------
    // Input decode
    // -------------------------------------------------------------------
    logic s_fire;
    logic wr_fire;
    logic q_fire;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign wr_fire = s_fire && (s_item.command == CMD_WRITE);
    assign q_fire  = s_fire && (s_item.command == CMD_QUERY);

    // window hits, offsets wrap at 16 bits
    logic [15:0] map_off;
    logic [15:0] font_off;
    logic [15:0] pal_off;
    logic        map_hit;
    logic        font_hit;
    logic        pal_hit;

    assign map_off  = s_item.address - map_base_reg;
    assign font_off = s_item.address - font_base_reg;
    assign pal_off  = s_item.address - palette_base_reg;
    assign map_hit  = wr_fire && (map_off  < 16'(MAP_DEPTH));
    assign font_hit = wr_fire && (font_off < 16'(FONT_DEPTH));
    assign pal_hit  = wr_fire && (pal_off  < 16'(PALETTE_DEPTH));

    // text area test and cell address
    logic [9:0]  x_ext;
    logic [9:0]  y_ext;
    logic [9:0]  xd;
    logic [9:0]  yd;
    logic        in_text;
    logic [15:0] cell_full;
    logic [MAP_AW-1:0] map_raddr;

    assign x_ext   = 10'(s_item.pixel_x);
    assign y_ext   = 10'(s_item.pixel_y);
    assign xd      = x_ext - 10'(MARGIN);
    assign yd      = y_ext - 10'(MARGIN);
    assign in_text = (x_ext >= 10'(MARGIN)) && (y_ext >= 10'(MARGIN)) &&
                     (xd < 10'(TEXT_W)) && (yd < 10'(TEXT_H));
    assign cell_full = 16'(yd[9:3]) * 16'(COLUMNS) + 16'(xd[9:2]);
    assign map_raddr = cell_full[MAP_AW-1:0];

    // -------------------------------------------------------------------
    // Character map RAM: one write port (snoop / clear), one read port
    // -------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            if (clr_cnt_reg < CLR_CW'(MAP_DEPTH)) begin
                map_mem[clr_cnt_reg[MAP_AW-1:0]] <= '0;
            end
        end else if (map_hit) begin
            map_mem[map_off[MAP_AW-1:0]] <= s_item.data;
        end
        if (q_fire && in_text) begin
            map_rdata_reg <= map_mem[map_raddr];
        end
    end

    // -------------------------------------------------------------------
    // Font RAM: word 2g holds columns 0/1, word 2g+1 columns 2/3
    // -------------------------------------------------------------------
    logic [7:0]         font_full;
    logic [FONT_AW-1:0] font_raddr;
    logic               glyph_ok;

    assign font_full  = {map_rdata_reg[6:0], cx_reg[1]};
    assign font_raddr = font_full[FONT_AW-1:0];
    assign glyph_ok   = {1'b0, map_rdata_reg[6:0]} < 8'(GLYPH_COUNT);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            if (clr_cnt_reg < CLR_CW'(FONT_DEPTH)) begin
                font_mem[clr_cnt_reg[FONT_AW-1:0]] <= '0;
            end
        end else if (font_hit) begin
            font_mem[font_off[FONT_AW-1:0]] <= s_item.data;
        end
        if (state_reg == ST_FONT) begin
            font_rdata_reg <= font_mem[font_raddr];
        end
    end

    // palette: 16 entries in flops, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PALETTE_DEPTH; i++) begin
                pal_reg[i] <= '0;
            end
        end else if (pal_hit) begin
            pal_reg[pal_off[3:0]] <= s_item.data[11:0];
        end
    end

    // -------------------------------------------------------------------
    // Colour stage
    // -------------------------------------------------------------------
    logic [7:0]  glyph_byte;
    logic        lit;
    logic [3:0]  colour_idx;
    logic [23:0] colour;
    logic        out_free;

    assign glyph_byte = cx_reg[0] ? font_rdata_reg[7:0] : font_rdata_reg[15:8];
    assign lit        = glyph_ok_reg && glyph_byte[cy_reg];
    assign colour_idx = border_reg ? border_index_reg :
                        (lit ? map_rdata_reg[15:12] : map_rdata_reg[11:8]);
    assign colour     = (palette_base_reg == 16'd0) ? default_colour(colour_idx) :
                        expand_colour(pal_reg[colour_idx]);
    assign out_free   = !m_valid_reg || m_ready;

    // -------------------------------------------------------------------
    // Sequencer and output register
    // -------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
            border_reg   <= 1'b0;
            glyph_ok_reg <= 1'b0;
        end else begin
            // the colour stage reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != ST_COLOR) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CLR_CW'(CLEAR_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (q_fire) begin
                        cx_reg     <= xd[1:0];
                        cy_reg     <= yd[2:0];
                        border_reg <= !in_text;
                        state_reg  <= in_text ? ST_FONT : ST_COLOR;
                    end
                end
                ST_FONT: begin
                    glyph_ok_reg <= glyph_ok;
                    state_reg    <= ST_COLOR;
                end
                ST_COLOR: begin
                    if (out_free) begin
                        m_item_reg.rgb       <= colour;
                        m_item_reg.is_border <= border_reg;
                        m_valid_reg          <= 1'b1;
                        state_reg            <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // -------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------
    a_text_query_reads_font: assert property (@(posedge aclk) disable iff (!aresetn)
        q_fire && in_text |=> state_reg == ST_FONT)
        else $error("text query did not move to font read");

    a_border_query_skips_font: assert property (@(posedge aclk) disable iff (!aresetn)
        q_fire && !in_text |=> state_reg == ST_COLOR && border_reg)
        else $error("border query did not go straight to colour stage");

    a_colour_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COLOR && out_free |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("colour stage did not load the output register");

    a_clear_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> clr_cnt_reg < CLR_CW'(CLEAR_DEPTH))
        else $error("clearing pass ran past the store depth");

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FONT |=> !s_fire)
        else $error("transaction accepted during query");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the tile text display pixel generator.
// Feeds snooped bus writes and pixel queries, predicts every pixel colour.
// Depends on ttd_pkg and tile_text_display_pixel_generator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttd_pkg::*;

    // Geometry at the block's default parameters
    localparam int COLUMNS     = 32;
    localparam int ROWS        = 12;
    localparam int MARGIN      = 16;
    localparam int GLYPH_COUNT = 128;
    localparam int CELL_W      = 4;
    localparam int CELL_H      = 8;
    localparam int MAP_DEPTH   = COLUMNS * ROWS;
    localparam int FONT_DEPTH  = 2 * GLYPH_COUNT;
    localparam int TEXT_W      = COLUMNS * CELL_W;
    localparam int TEXT_H      = ROWS * CELL_H;

    // Run shape
    localparam int PHASE_ITEMS   = 190;
    localparam int SETTLE_CYCLES = 10;       // outlasts the longest query
    localparam int LIMIT_CYCLES  = 200000;   // watchdog limit

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    ttd_in_t     s_item  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    ttd_out_t    m_item;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    tile_text_display_pixel_generator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: register copies and shadow stores
    // ------------------------------------------------------------------
    logic [15:0] map_origin     = '0;
    logic [15:0] font_origin    = '0;
    logic [15:0] palette_origin = '0;
    logic [3:0]  border_pick    = '0;
    logic [15:0] char_cells   [MAP_DEPTH];
    logic [15:0] glyph_rows   [FONT_DEPTH];
    logic [11:0] palette_regs [PALETTE_DEPTH];

    ttd_in_t     pending_cmds[$];   // transactions waiting for the driver
    ttd_out_t    colour_due[$];     // predicted pixels, oldest first
    int unsigned cycle_count = 0;
    int unsigned fault_count = 0;
    bit          calm        = 1'b0;   // no idling on either side

    // Driver / monitor idling state
    bit          feed_idle   = 1'b0;
    int unsigned feed_gap    = 0;
    bit          drain_idle  = 1'b0;
    int unsigned drain_stall = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Palette entry as 24-bit RGB; palette_origin of zero selects the
    // built-in set, else 4-bit channels scaled by 17
    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [11:0] v;
        if (palette_origin != 16'd0) begin
            v = palette_regs[idx];
            r = 8'(v[11:8]) * 8'd17;
            g = 8'(v[7:4]) * 8'd17;
            b = 8'(v[3:0]) * 8'd17;
        end else begin
            b = idx[0] ? LEVEL_HI : 8'd0;
            g = idx[1] ? LEVEL_HI : 8'd0;
            r = idx[2] ? LEVEL_HI : 8'd0;
            if (idx == 4'd6) begin
                g = g - LEVEL_LO;          // brown
            end else if (idx[3]) begin
                r = r + LEVEL_LO;
                g = g + LEVEL_LO;
                b = b + LEVEL_LO;
            end
        end
        return {r, g, b};
    endfunction

    // Applies one accepted transaction to the shadow stores; returns 1 with
    // the expected pixel for a query, 0 for a snooped write
    function automatic bit display_step(input ttd_in_t item, output ttd_out_t pixel);
        logic [15:0] off;
        logic [15:0] cell_word;
        logic [15:0] glyph_word;
        logic [7:0]  column_bits;
        logic        lit;
        int          x;
        int          y;
        int          cx;
        int          cy;
        pixel = '0;
        if (item.command == CMD_WRITE) begin
            // one write may hit several windows; offsets wrap at 16 bits
            off = item.address - map_origin;
            if (off < MAP_DEPTH) char_cells[off] = item.data;
            off = item.address - font_origin;
            if (off < FONT_DEPTH) glyph_rows[off] = item.data;
            off = item.address - palette_origin;
            if (off < PALETTE_DEPTH) palette_regs[off] = item.data[11:0];
            return 1'b0;
        end
        x = item.pixel_x;
        y = item.pixel_y;
        // anything outside the text area is border, also beyond the frame
        if (x < MARGIN || y < MARGIN || x - MARGIN >= TEXT_W || y - MARGIN >= TEXT_H) begin
            pixel.rgb       = palette_rgb(border_pick);
            pixel.is_border = 1'b1;
            return 1'b1;
        end
        x  = x - MARGIN;
        y  = y - MARGIN;
        cx = x % CELL_W;
        cy = y % CELL_H;
        cell_word = char_cells[(y / CELL_H) * COLUMNS + x / CELL_W];
        lit = 1'b0;
        if (cell_word[6:0] < GLYPH_COUNT) begin
            // word 0: columns 0/1, word 1: columns 2/3; high byte is the even column
            glyph_word  = glyph_rows[cell_word[6:0] * 2 + cx / 2];
            column_bits = (cx % 2 == 1) ? glyph_word[7:0] : glyph_word[15:8];
            lit         = column_bits[cy];
        end
        pixel.rgb       = palette_rgb(lit ? cell_word[15:12] : cell_word[11:8]);
        pixel.is_border = 1'b0;
        return 1'b1;
    endfunction

    // Unused fields get random values so every input bit toggles
    function automatic ttd_in_t bus_write(input logic [15:0] addr, input logic [15:0] value);
        ttd_in_t it;
        it.command = CMD_WRITE;
        it.address = addr;
        it.data    = value;
        it.pixel_x = 8'($urandom);
        it.pixel_y = 7'($urandom);
        return it;
    endfunction

    function automatic ttd_in_t pixel_query(input logic [7:0] x, input logic [6:0] y);
        ttd_in_t it;
        it.command = CMD_QUERY;
        it.address = 16'($urandom);
        it.data    = 16'($urandom);
        it.pixel_x = x;
        it.pixel_y = y;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued transactions, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : feed_proc
        ttd_out_t pixel;
        bit       took;
        took = s_valid && s_ready;
        if (cycle_count % 64 == 0) begin
            feed_idle = ($urandom_range(0, 2) != 0);
        end
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (took && display_step(s_item, pixel)) begin
                colour_due.push_back(pixel);
            end
            // valid only drops or changes once the current transaction is taken
            if (!s_valid || took) begin
                if (feed_gap == 0 && feed_idle && !calm && $urandom_range(0, 3) == 0) begin
                    feed_gap = $urandom_range(1, 11);
                end
                if (feed_gap > 0) begin
                    feed_gap--;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    s_item  <= pending_cmds.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result against the oldest prediction, random stalls
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drain_proc
        ttd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (colour_due.size() == 0) begin
                $error("unexpected result: rgb %06h is_border %b", m_item.rgb, m_item.is_border);
                fault_count++;
            end else begin
                want = colour_due.pop_front();
                if (m_item.rgb !== want.rgb) begin
                    $error("rgb expected %06h actual %06h", want.rgb, m_item.rgb);
                    fault_count++;
                end
                if (m_item.is_border !== want.is_border) begin
                    $error("is_border expected %b actual %b", want.is_border, m_item.is_border);
                    fault_count++;
                end
            end
        end
        if (cycle_count % 64 == 32) begin
            drain_idle = ($urandom_range(0, 2) != 0);
        end
        if (drain_stall > 0) begin
            drain_stall--;
            m_ready <= 1'b0;
        end else if (drain_idle && !calm && $urandom_range(0, 4) == 0) begin
            drain_stall = $urandom_range(0, 10);    // stall for a random burst
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    // APB write: setup then access; register lands when pready is seen
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only the register's own width is kept
        case (idx)
            REG_MAP_BASE:     map_origin     = value[15:0];
            REG_FONT_BASE:    font_origin    = value[15:0];
            REG_PALETTE_BASE: palette_origin = value[15:0];
            REG_BORDER_INDEX: border_pick    = value[3:0];
            default: ;
        endcase
    endtask

    // Block is idle once everything is taken and every pixel has come back;
    // trailing writes produce nothing, so let the pipeline settle too
    task automatic wait_drained();
        do @(posedge aclk); while (pending_cmds.size() != 0 || s_valid || colour_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One setting of the registers followed by random traffic aimed mostly at
    // the current windows and the text area
    task automatic run_phase(input logic [15:0] map_at, input logic [15:0] font_at,
                             input logic [15:0] pal_at, input logic [3:0] border,
                             input bit quiet);
        int      pick;
        ttd_in_t it;
        // junk in the upper bits must be dropped by the register file
        apb_write(REG_MAP_BASE, {16'($urandom), map_at});
        apb_write(REG_FONT_BASE, {16'($urandom), font_at});
        apb_write(REG_PALETTE_BASE, {16'($urandom), pal_at});
        apb_write(REG_BORDER_INDEX, {28'($urandom), border});
        calm = quiet;
        repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                it = bus_write(map_origin + 16'($urandom_range(0, MAP_DEPTH - 1)), 16'($urandom));
            end else if (pick < 32) begin
                it = bus_write(font_origin + 16'($urandom_range(0, FONT_DEPTH - 1)), 16'($urandom));
            end else if (pick < 38) begin
                it = bus_write(palette_origin + 16'($urandom_range(0, PALETTE_DEPTH - 1)),
                               16'($urandom));
            end else if (pick < 42) begin
                it = bus_write(16'($urandom), 16'($urandom));
            end else if (pick < 85) begin
                it = pixel_query(8'(MARGIN + $urandom_range(0, TEXT_W - 1)),
                                 7'(MARGIN + $urandom_range(0, TEXT_H - 1)));
            end else if (pick < 95) begin
                it = pixel_query(8'($urandom_range(0, 159)), 7'($urandom_range(0, 127)));
            end else begin
                it = pixel_query(8'($urandom), 7'($urandom));
            end
            pending_cmds.push_back(it);
        end
        wait_drained();
    endtask

    initial begin
        // stores are all zero after reset
        for (int i = 0; i < MAP_DEPTH; i++) char_cells[i] = '0;
        for (int i = 0; i < FONT_DEPTH; i++) glyph_rows[i] = '0;
        for (int i = 0; i < PALETTE_DEPTH; i++) palette_regs[i] = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at reset settings: all bases zero, so map, font and
        // palette windows overlap and the built-in palette is used. The first
        // transactions wait out the clearing pass.
        pending_cmds.push_back(pixel_query(8'd0, 7'd0));        // border, untouched
        pending_cmds.push_back(pixel_query(8'd16, 7'd16));      // first text pixel, blank
        pending_cmds.push_back(bus_write(16'd0, 16'hF181));     // map/font/palette at once
        pending_cmds.push_back(bus_write(16'd2, 16'hFF01));     // glyph 1, columns 0/1
        pending_cmds.push_back(bus_write(16'd3, 16'h8000));     // glyph 1, columns 2/3
        pending_cmds.push_back(pixel_query(8'd16, 7'd16));      // lit, fg 15
        pending_cmds.push_back(pixel_query(8'd17, 7'd16));      // lit from low byte
        pending_cmds.push_back(pixel_query(8'd17, 7'd17));      // clear, bg 1
        pending_cmds.push_back(pixel_query(8'd18, 7'd23));      // row 7 of column 2
        pending_cmds.push_back(pixel_query(8'd19, 7'd23));
        pending_cmds.push_back(bus_write(16'd383, 16'h2EFF));   // last cell, glyph 127
        pending_cmds.push_back(bus_write(16'd255, 16'h00FF));   // last font word
        pending_cmds.push_back(pixel_query(8'd143, 7'd111));    // last text pixel, lit
        pending_cmds.push_back(pixel_query(8'd142, 7'd111));    // bg 14
        pending_cmds.push_back(pixel_query(8'd144, 7'd111));    // right margin
        pending_cmds.push_back(pixel_query(8'd143, 7'd112));    // bottom margin
        pending_cmds.push_back(pixel_query(8'd15, 7'd60));      // left margin
        pending_cmds.push_back(pixel_query(8'd60, 7'd15));      // top margin
        pending_cmds.push_back(pixel_query(8'd159, 7'd127));    // frame corner
        pending_cmds.push_back(pixel_query(8'd255, 7'd127));    // beyond the frame
        pending_cmds.push_back(bus_write(16'hFFFF, 16'hFFFF));  // outside every window
        wait_drained();

        // Register settings: default palette with brown border, windows that
        // wrap past 0xFFFF, overlapping windows, extremes, then random ones
        run_phase(16'h1000, 16'h2000, 16'h0000, 4'd6, 1'b0);
        run_phase(16'hFF00, 16'hFFFF, 16'hFFF8, 4'd15, 1'b0);
        run_phase(16'h4000, 16'h4100, 16'h4170, 4'd9, 1'b0);
        run_phase(16'hFFFF, 16'h0000, 16'h0001, 4'd0, 1'b0);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
                  4'($urandom), 1'b0);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 4'($urandom), 1'b1);

        if (fault_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ttd_pkg.sv
hw/rtl/tile_text_display_pixel_generator.sv
tb/tb.sv
